@@ src/co2ws_pkg.sv @@
package co2ws_pkg;

   // Ring and window geometry
   localparam int RING_DEPTH = 64;
   localparam int WINDOW     = 16;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int WIN_MOD    = WINDOW % RING_DEPTH;
   localparam int CNT_W      = $clog2(WINDOW + 1);

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int MIN_W    = 14;
   localparam int MEAN_W   = 16;
   localparam int ROOT_W   = 16;
   localparam int N_W      = 5;

   // Accumulator and arithmetic widths
   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
   localparam int NUM_W   = SUM_W + 1;
   localparam int DEN_W   = N_W + 1;
   localparam int SQ_W    = 2 * SAMPLE_W + $clog2(WINDOW);
   localparam int MUL_W   = ROOT_W + 1;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int CMP_W   = PROD_W + N_W;
   localparam int STEP_W  = $clog2(NUM_W);
   localparam int ROOT_BW = $clog2(ROOT_W);

   localparam logic [MIN_W-1:0] MIN_START = MIN_W'(10000);

   // Request operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_DEV,
      ST_ROOT_SQ,
      ST_ROOT_CMP
   } co2ws_state_type;

endpackage

@@ src/co2_window_statistics.sv @@
// A record request (start high while busy is low) stores one sample in the
// ring and completes in that cycle; it gives no response and busy stays low.
// A query request raises busy while it walks the window
// through the ring's registered read port, runs the bit-serial divide that
// forms the mean, makes a second window walk that squares deviations on the
// shared 17x17 multiplier, and runs the 16-bit square root search (ST_ROOT_SQ
// then ST_ROOT_CMP for each bit, on the same multiplier). An empty window skips the divide,
// deviation and root and answers after the first walk. The response appears on
// the rsp_ ports for exactly one cycle, marked by rsp_valid; the receiver
// cannot stall it, so it must capture the response in that cycle. Ring
// entries read as zero until first written, right after reset.
module co2_window_statistics (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_operation,
   input  logic [co2ws_pkg::SAMPLE_W-1:0]  req_co2_sample,
   output logic                            rsp_valid,
   output logic [co2ws_pkg::MIN_W-1:0]     rsp_min_ppm,
   output logic [co2ws_pkg::SAMPLE_W-1:0]  rsp_max_ppm,
   output logic [co2ws_pkg::MEAN_W-1:0]    rsp_mean_ppm,
   output logic [co2ws_pkg::ROOT_W-1:0]    rsp_deviation_ppm,
   output logic [co2ws_pkg::N_W-1:0]       rsp_valid_count,
   output logic                            rsp_no_samples
);
   import co2ws_pkg::*;

   co2ws_state_type state_ff, state_in;

   logic [SAMPLE_W-1:0]   ring_mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] ring_ok_ff, ring_ok_in;
   logic [RING_AW-1:0]    wr_idx_ff, wr_idx_in;
   logic [RING_AW-1:0]    addr_ff, addr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rd_tag_ff, rd_tag_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [SAMPLE_W-1:0]   rd_data_ff;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  prod_tag_ff, prod_tag_in;
   logic [MIN_W-1:0]      min_ff, min_in;
   logic [SAMPLE_W-1:0]   max_ff, max_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [N_W-1:0]        n_ff, n_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [N_W-1:0]        rem_ff, rem_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MIN_W-1:0]      rsp_min_ff, rsp_min_in;
   logic [SAMPLE_W-1:0]   rsp_max_ff, rsp_max_in;
   logic [MEAN_W-1:0]     rsp_mean_ff, rsp_mean_in;
   logic [ROOT_W-1:0]     rsp_dev_ff, rsp_dev_in;
   logic [N_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  accept;
   logic                  rec_wr;
   logic                  rd_en;
   logic [RING_AW-1:0]    win_start;
   logic [SAMPLE_W-1:0]   sample_v;
   logic                  hit;
   logic [MEAN_W-1:0]     mean_w;
   logic [SAMPLE_W-1:0]   diff;
   logic [ROOT_W-1:0]     cand;
   logic [MUL_W-1:0]      mul_a;
   logic [DEN_W-1:0]      den;
   logic [DEN_W-1:0]      shifted;
   logic                  div_ge;
   logic [CMP_W-1:0]      cmp_lhs;
   logic [CMP_W-1:0]      cmp_rhs;
   logic                  root_keep;
   logic                  walk_done;

   // Decode request handshake
   assign accept    = start && !busy;
   assign rec_wr    = accept && (req_operation == OP_RECORD);
   assign win_start = wr_idx_ff - RING_AW'(WIN_MOD);
   assign rd_en     = ((state_ff == ST_SCAN) || (state_ff == ST_DEV))
                      && (cnt_ff != CNT_W'(WINDOW));
   assign walk_done = (cnt_ff == CNT_W'(WINDOW)) && !rd_tag_ff && !prod_tag_ff;

   // Sample from the read port; unwritten entries read as zero
   assign sample_v = rd_ok_ff ? rd_data_ff : '0;
   assign hit      = rd_tag_ff && (sample_v != '0);

   // Absolute deviation from the rounded mean
   assign mean_w = num_ff[MEAN_W-1:0];
   assign diff   = (sample_v >= mean_w) ? (sample_v - mean_w) : (mean_w - sample_v);

   // Root candidate and shared multiplier
   assign cand    = root_ff | (ROOT_W'(1) << step_ff[ROOT_BW-1:0]);
   assign mul_a   = (state_ff == ST_DEV) ? {1'b0, diff} : ({cand, 1'b0} - MUL_W'(1));
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_a);

   // Divide step: one quotient bit per cycle
   assign den     = {n_ff, 1'b0};
   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge  = (shifted >= den);

   // Root test: (2c-1)^2 * n <= 4S
   assign cmp_lhs   = CMP_W'(prod_ff) * CMP_W'(n_ff);
   assign cmp_rhs   = CMP_W'({sq_ff, 2'b00});
   assign root_keep = (cmp_lhs <= cmp_rhs);

   // Sequence the query and update the datapath
   always_comb begin
      state_in     = state_ff;
      ring_ok_in   = ring_ok_ff;
      wr_idx_in    = wr_idx_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rd_tag_in    = rd_en;
      rd_ok_in     = rd_en && ring_ok_ff[addr_ff];
      prod_tag_in  = (state_ff == ST_DEV) && hit;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_dev_in   = rsp_dev_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;

      if (rd_en) begin
         addr_in = addr_ff + RING_AW'(1);
         cnt_in  = cnt_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (rec_wr) begin
               ring_ok_in[wr_idx_ff] = 1'b1;
               wr_idx_in             = wr_idx_ff + RING_AW'(1);
            end else if (accept) begin
               state_in = ST_SCAN;
               addr_in  = win_start;
               cnt_in   = '0;
               min_in   = MIN_START;
               max_in   = '0;
               sum_in   = '0;
               n_in     = '0;
            end
         end
         ST_SCAN: begin
            // Accumulate min, max, sum and count
            if (hit) begin
               if (sample_v < SAMPLE_W'(min_ff)) begin
                  min_in = sample_v[MIN_W-1:0];
               end
               if (sample_v > max_ff) begin
                  max_in = sample_v;
               end
               sum_in = sum_ff + SUM_W'(sample_v);
               n_in   = n_ff + N_W'(1);
            end
            if (walk_done) begin
               if (n_ff == '0) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_min_in   = min_ff;
                  rsp_max_in   = max_ff;
                  rsp_mean_in  = '0;
                  rsp_dev_in   = '0;
                  rsp_count_in = '0;
                  rsp_empty_in = 1'b1;
               end else begin
                  state_in = ST_DIVIDE;
                  num_in   = {sum_ff, 1'b0} + NUM_W'(n_ff);
                  rem_in   = '0;
                  step_in  = STEP_W'(NUM_W - 1);
               end
            end
         end
         ST_DIVIDE: begin
            // Shift in one quotient bit
            num_in = {num_ff[NUM_W-2:0], div_ge};
            rem_in = div_ge ? N_W'(shifted - den) : shifted[N_W-1:0];
            if (step_ff == '0) begin
               state_in = ST_DEV;
               addr_in  = win_start;
               cnt_in   = '0;
               sq_in    = '0;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DEV: begin
            // Accumulate squared deviations
            if (prod_tag_ff) begin
               sq_in = sq_ff + SQ_W'(prod_ff);
            end
            if (walk_done) begin
               state_in = ST_ROOT_SQ;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_W - 1);
            end
         end
         ST_ROOT_SQ: begin
            state_in = ST_ROOT_CMP;
         end
         ST_ROOT_CMP: begin
            // Keep the candidate bit if its test passes
            if (root_keep) begin
               root_in = cand;
            end
            if (step_ff[ROOT_BW-1:0] == '0) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_min_in   = min_ff;
               rsp_max_in   = max_ff;
               rsp_mean_in  = mean_w;
               rsp_dev_in   = root_keep ? cand : root_ff;
               rsp_count_in = n_ff;
               rsp_empty_in = 1'b0;
            end else begin
               state_in = ST_ROOT_SQ;
               step_in  = step_ff - STEP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ok_ff   <= '0;
         wr_idx_ff    <= '0;
         cnt_ff       <= '0;
         rd_tag_ff    <= 1'b0;
         rd_ok_ff     <= 1'b0;
         prod_tag_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ring_ok_ff   <= ring_ok_in;
         wr_idx_ff    <= wr_idx_in;
         cnt_ff       <= cnt_in;
         rd_tag_ff    <= rd_tag_in;
         rd_ok_ff     <= rd_ok_in;
         prod_tag_ff  <= prod_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      prod_ff      <= prod_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      sum_ff       <= sum_in;
      n_ff         <= n_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      sq_ff        <= sq_in;
      root_ff      <= root_in;
      step_ff      <= step_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_dev_ff   <= rsp_dev_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Sample ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (rec_wr) begin
         ring_mem[wr_idx_ff] <= req_co2_sample;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[addr_ff];
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_min_ppm       = rsp_min_ff;
   assign rsp_max_ppm       = rsp_max_ff;
   assign rsp_mean_ppm      = rsp_mean_ff;
   assign rsp_deviation_ppm = rsp_dev_ff;
   assign rsp_valid_count   = rsp_count_ff;
   assign rsp_no_samples    = rsp_empty_ff;

endmodule
